@@ hdl/bees_pkg.sv @@
// Package for the Bragg edge elastic scatter block: beat types and constants.
// Used by bragg_edge_elastic_scatter_top and its testbench. No dependencies.
`timescale 1ns / 1ps

package bees_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	// command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// +1.0 of the cosine scale
	localparam logic signed [31:0] COSINE_ONE = 32'sh4000_0000;
	localparam logic [31:0] XS_SAT = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        command;
		logic [7:0]  entry_index;
		logic [31:0] edge_energy;
		logic [31:0] cumulative_strength;
		logic [31:0] neutron_energy;
		logic [31:0] random_fraction;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        cross_section;
		logic signed [31:0] scatter_cosine;
		logic [8:0]         edges_below;
		logic [7:0]         chosen_edge;
	} out_item_t;

endpackage

@@ hdl/bees_div.sv @@
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Used by bragg_edge_elastic_scatter_top. No package dependencies.
`timescale 1ns / 1ps

module bees_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	logic [63:0] work_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        take;

	// one trial subtraction a cycle
	assign trial = {rem_q, work_q[63]};
	assign diff  = trial - {1'b0, dvs_q};
	assign take  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= take ? diff[31:0] : trial[31:0];
			work_q <= {work_q[62:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = work_q;
endmodule

@@ hdl/bragg_edge_elastic_scatter_top.sv @@
// Bragg edge coherent elastic scatter unit: table memories, sequencer, result register.
// Depends on bees_pkg and bees_div.
`timescale 1ns / 1ps
//
// Usage
//   in channel : in_valid / in_stall / in_data. A load beat writes one table
//                entry; a query beat returns cross-section, cosine, edge count
//                and sampled edge. in_stall is high while an item is at work.
//   out channel: out_valid / out_stall / out_data, one beat per input beat,
//                held in an output register so the next item may be taken
//                while a result waits.
//   cfg channel: cfg_valid / cfg_ready / cfg_data writes edge_count; always
//                ready, write only while idle.
// Sequence
//   A load goes straight to the output state. A query walks the edge table
//   and then the strength table through registered reads at one shared
//   address, then runs two passes of the shared restoring divider, one for
//   the cross-section and one for the cosine.
//   A query counting no edges, or of zero energy, skips the divider.
// Reset
//   arst_n clears the sequencer and output valid; edge_count returns to 1.
//   Table contents are undefined until loaded. A stalled receiver holds the
//   result; the block finishes its item and waits in its output state.

module bragg_edge_elastic_scatter_top #(
	parameter int TABLE_DEPTH = bees_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  bees_pkg::in_item_t in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output bees_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [8:0]         cfg_data
);
	import bees_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CNT_WAIT, ST_CNT_CMP, ST_TOT_WAIT, ST_TOT_CAP,
		ST_SMP_WAIT, ST_SMP_CMP, ST_EDG_WAIT, ST_EDG_CAP,
		ST_XS_DIV, ST_MU_DIV, ST_OUT
	} state_t;

	state_t      state_q;
	logic [8:0]  edge_count_q;
	logic [CW-1:0] cnt_eff;
	logic [CW-1:0] n_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] n_next;
	logic [CW-1:0] i_next;
	logic [AW-1:0] addr_q;
	logic [31:0] energy_q;
	logic [31:0] rnd_q;
	logic [31:0] total_q;
	logic [63:0] target_q;
	logic [31:0] edge_sel_q;
	logic [31:0] xs_q;
	logic signed [31:0] mu_q;
	logic [7:0]  chosen_q;
	out_item_t   res;
	logic        out_valid_q;
	out_item_t   out_q;
	logic        in_acc;
	logic        out_free;

	// table memories
	logic [31:0] edge_mem [TABLE_DEPTH];
	logic [31:0] str_mem  [TABLE_DEPTH];
	logic [31:0] edge_rd_q;
	logic [31:0] str_rd_q;

	// shared divider
	logic        div_start;
	logic [63:0] div_dividend;
	logic        div_done;
	logic [63:0] div_quot;
	logic [31:0] q_clamp;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cnt_eff = (32'(edge_count_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(edge_count_q);
	assign n_next  = n_q + CW'(1);
	assign i_next  = i_q + CW'(1);

	// memory write on load, registered read
	always_ff @(posedge clk) begin
		if (in_acc && in_data.command == CMD_LOAD &&
			32'(in_data.entry_index) < TABLE_DEPTH) begin
			edge_mem[AW'(in_data.entry_index)] <= in_data.edge_energy;
			str_mem[AW'(in_data.entry_index)]  <= in_data.cumulative_strength;
		end
		edge_rd_q <= edge_mem[addr_q];
		str_rd_q  <= str_mem[addr_q];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= 9'd1;
		end else if (cfg_valid && cfg_ready) begin
			edge_count_q <= cfg_data;
		end
	end

	// divider start and operand select
	always_comb begin
		div_start    = 1'b0;
		div_dividend = {total_q, 24'd0, 8'd0} >> 8;
		if (state_q == ST_EDG_CAP && energy_q != 32'd0) begin
			div_start = 1'b1;
		end else if (state_q == ST_XS_DIV && div_done) begin
			div_start    = 1'b1;
			div_dividend = {1'b0, edge_sel_q, 31'd0};
		end
	end

	bees_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (energy_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign q_clamp = (div_quot > 64'h8000_0000) ? 32'h8000_0000 : div_quot[31:0];

	always_comb begin
		res.cross_section  = xs_q;
		res.scatter_cosine = mu_q;
		res.edges_below    = 9'(n_q);
		res.chosen_edge    = chosen_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// output valid: set when a result is loaded, cleared when taken
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						energy_q <= in_data.neutron_energy;
						rnd_q    <= in_data.random_fraction;
						n_q      <= '0;
						i_q      <= '0;
						addr_q   <= '0;
						chosen_q <= '0;
						xs_q     <= '0;
						mu_q     <= '0;
						if (in_data.command == CMD_LOAD) begin
							state_q <= ST_OUT;
						end else if (cnt_eff == '0) begin
							mu_q    <= COSINE_ONE;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_CNT_WAIT;
						end
					end
				end
				ST_CNT_WAIT: state_q <= ST_CNT_CMP;
				// count edges at or below the energy
				ST_CNT_CMP: begin
					if (edge_rd_q <= energy_q) begin
						n_q <= n_next;
						if (n_next < cnt_eff) begin
							addr_q  <= AW'(n_next);
							state_q <= ST_CNT_WAIT;
						end else begin
							addr_q  <= AW'(n_q);
							state_q <= ST_TOT_WAIT;
						end
					end else if (n_q == '0) begin
						mu_q    <= COSINE_ONE;
						state_q <= ST_OUT;
					end else begin
						addr_q  <= AW'(n_q - CW'(1));
						state_q <= ST_TOT_WAIT;
					end
				end
				ST_TOT_WAIT: state_q <= ST_TOT_CAP;
				ST_TOT_CAP: begin
					total_q  <= str_rd_q;
					target_q <= 64'(rnd_q) * 64'(str_rd_q);
					addr_q   <= '0;
					i_q      <= '0;
					state_q  <= ST_SMP_WAIT;
				end
				ST_SMP_WAIT: state_q <= ST_SMP_CMP;
				// first edge whose strength exceeds the target
				ST_SMP_CMP: begin
					if ({str_rd_q, 32'd0} > target_q) begin
						chosen_q <= 8'(i_q);
						addr_q   <= AW'(i_q);
						state_q  <= ST_EDG_WAIT;
					end else if (i_next < n_q) begin
						i_q     <= i_next;
						addr_q  <= AW'(i_next);
						state_q <= ST_SMP_WAIT;
					end else begin
						chosen_q <= 8'(i_q);
						addr_q   <= AW'(i_q);
						state_q  <= ST_EDG_WAIT;
					end
				end
				ST_EDG_WAIT: state_q <= ST_EDG_CAP;
				ST_EDG_CAP: begin
					edge_sel_q <= edge_rd_q;
					if (energy_q == 32'd0) begin
						xs_q    <= XS_SAT;
						mu_q    <= COSINE_ONE;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_XS_DIV;
					end
				end
				ST_XS_DIV: begin
					if (div_done) begin
						xs_q    <= (div_quot[63:32] != 32'd0) ? XS_SAT : div_quot[31:0];
						state_q <= ST_MU_DIV;
					end
				end
				ST_MU_DIV: begin
					if (div_done) begin
						mu_q    <= COSINE_ONE - $signed(q_clamp);
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_q   <= res;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ verif/bragg_edge_elastic_scatter_top_test.sv @@
// Testbench for the Bragg edge elastic scatter unit: table loads, queries, edge counts.
// Depends on bees_pkg and bragg_edge_elastic_scatter_top; predicts every result itself.
`timescale 1ns / 1ps

module bragg_edge_elastic_scatter_top_test;
	import bees_pkg::*;

	localparam int DEPTH = 256;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [8:0] cfg_data;

	bragg_edge_elastic_scatter_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// predictor state
	logic [31:0] edge_mirror [DEPTH];
	logic [31:0] strength_mirror [DEPTH];
	logic [8:0] count_mirror;
	out_item_t scatter_results [$];

	int errors;
	int beats_out;
	int queries_sent;
	int idle_pct;
	int idle_cycles;
	bit done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// predict one result and update the mirrors
	function automatic out_item_t predict_scatter(in_item_t it);
		out_item_t r;
		int cnt, n, chosen;
		logic [63:0] total, xs, target, q;
		longint mu;
		r = '0;
		if (it.command == CMD_LOAD) begin
			edge_mirror[it.entry_index] = it.edge_energy;
			strength_mirror[it.entry_index] = it.cumulative_strength;
			return r;
		end
		cnt = (count_mirror > DEPTH) ? DEPTH : count_mirror;
		n = 0;
		while (n < cnt && edge_mirror[n] <= it.neutron_energy) n++;
		if (n == 0) begin
			r.scatter_cosine = COSINE_ONE;
			return r;
		end
		total = {32'd0, strength_mirror[n-1]};
		if (it.neutron_energy == 0) xs = 64'hFFFF_FFFF;
		else begin
			xs = (total << 24) / it.neutron_energy;
			if (xs > 64'hFFFF_FFFF) xs = 64'hFFFF_FFFF;
		end
		target = {32'd0, it.random_fraction} * total;
		chosen = n - 1;
		for (int i = 0; i < n; i++)
			if ({strength_mirror[i], 32'd0} > target) begin
				chosen = i;
				break;
			end
		if (it.neutron_energy == 0) mu = 64'sd1 << 30;
		else begin
			q = ({32'd0, edge_mirror[chosen]} << 31) / it.neutron_energy;
			if (q > (64'd1 << 31)) q = 64'd1 << 31;
			mu = (64'sd1 << 30) - longint'(q);
		end
		if (mu > (64'sd1 << 30)) mu = 64'sd1 << 30;
		if (mu < -(64'sd1 << 30)) mu = -(64'sd1 << 30);
		r.cross_section = xs[31:0];
		r.scatter_cosine = mu[31:0];
		r.edges_below = n[8:0];
		r.chosen_edge = chosen[7:0];
		return r;
	endfunction

	// send one beat, with random idling before it; valid stays up after the
	// beat until an idle cycle or a drain drops it
	task automatic send_beat(in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		scatter_results.push_back(predict_scatter(it));
		if (it.command == CMD_QUERY) queries_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (scatter_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_edge_count(logic [8:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		count_mirror = value;
	endtask

	task automatic send_load(int idx, logic [31:0] e, logic [31:0] s);
		in_item_t it;
		it = '0;
		it.command = CMD_LOAD;
		it.entry_index = idx[7:0];
		it.edge_energy = e;
		it.cumulative_strength = s;
		it.neutron_energy = $urandom;
		it.random_fraction = $urandom;
		send_beat(it);
	endtask

	task automatic send_query(logic [31:0] e, logic [31:0] r);
		in_item_t it;
		it = '0;
		it.command = CMD_QUERY;
		it.entry_index = 8'($urandom);
		it.edge_energy = $urandom;
		it.cumulative_strength = $urandom;
		it.neutron_energy = e;
		it.random_fraction = r;
		send_beat(it);
	endtask

	// sorted table of k entries with rising cumulative strength
	task automatic load_sorted_table(int k, bit wide);
		logic [31:0] e, s;
		e = wide ? $urandom_range(32'h0000_FFFF) : 32'h0;
		s = $urandom_range(255);
		for (int i = 0; i < k; i++) begin
			send_load(i, e, s);
			e = e + (wide ? $urandom_range(32'h00FF_FFFF) : $urandom_range(32'h000F_FFFF));
			s = s + $urandom_range(32'h000F_FFFF);
		end
	endtask

	function automatic logic [31:0] pick_energy(int k);
		int j;
		j = $urandom_range(k - 1);
		case ($urandom_range(5))
			0: return edge_mirror[j];
			1: return edge_mirror[j] + 1;
			2: return edge_mirror[j] - 1;
			3: return 32'h0;
			4: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_fraction();
		case ($urandom_range(3))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// directed: extremes, no edge counted, zero energy, saturation, ignored index
	task automatic test_directed();
		write_edge_count(9'd4);
		send_load(0, 32'h0100_0000, 32'h0000_0001);
		send_load(1, 32'h0200_0000, 32'h0001_0000);
		send_load(2, 32'h8000_0000, 32'h8000_0000);
		send_load(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_query(32'h0080_0000, 32'h1234_5678);
		send_query(32'h0100_0000, 32'h0);
		send_query(32'h0180_0000, 32'hFFFF_FFFF);
		send_query(32'hFFFF_FFFF, 32'h8000_0000);
		send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_query(32'h0000_0001, 32'h0);
		send_load(255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_load(0, 32'h0, 32'hFFFF_FFFF);
		send_query(32'h0, 32'h4000_0000);
		send_query(32'h0000_0002, 32'hFFFF_FFFF);
		write_edge_count(9'd0);
		send_query(32'hFFFF_FFFF, 32'h0);
		write_edge_count(9'd256);
		for (int i = 4; i < 255; i++) send_load(i, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_query(32'hFFFF_FFFF, 32'h8000_0000);
		write_edge_count(9'd511);
		send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_query(32'h0, 32'h0);
	endtask

	// random: sorted tables of several sizes, queries about the edges, some noise
	task automatic test_random(int phases, int per_phase);
		int k;
		logic [8:0] cnt;
		for (int p = 0; p < phases; p++) begin
			idle_pct = (p == 2) ? 0 : 12;
			k = (p % 7 == 6) ? DEPTH : $urandom_range(1, 12);
			drain_results();
			load_sorted_table(k, 1'($urandom_range(1)));
			case ($urandom_range(3))
				0: cnt = 9'(k);
				1: cnt = 9'($urandom_range(1, k));
				2: cnt = 9'd0;
				default: cnt = (k == DEPTH) ? 9'h1FF : 9'(k);
			endcase
			write_edge_count(cnt);
			for (int i = 0; i < per_phase; i++) begin
				if ($urandom_range(19) == 0)
					send_load($urandom_range(k - 1) + 0, $urandom, $urandom);
				else
					send_query(pick_energy(k), pick_fraction());
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin : check_blk
		out_item_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			beats_out <= beats_out + 1;
			if (scatter_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				exp_r = scatter_results.pop_front();
				if (out_data.cross_section !== exp_r.cross_section) begin
					$display("%0t: cross_section exp %h got %h", $time,
						exp_r.cross_section, out_data.cross_section);
					errors++;
				end
				if (out_data.scatter_cosine !== exp_r.scatter_cosine) begin
					$display("%0t: scatter_cosine exp %h got %h", $time,
						exp_r.scatter_cosine, out_data.scatter_cosine);
					errors++;
				end
				if (out_data.edges_below !== exp_r.edges_below) begin
					$display("%0t: edges_below exp %0d got %0d", $time,
						exp_r.edges_below, out_data.edges_below);
					errors++;
				end
				if (out_data.chosen_edge !== exp_r.chosen_edge) begin
					$display("%0t: chosen_edge exp %0d got %0d", $time,
						exp_r.chosen_edge, out_data.chosen_edge);
					errors++;
				end
			end
		end
	end

	// receiver stall
	always @(posedge clk) begin
		if (!arst_n) out_stall <= 1'b0;
		else out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
	end

	// watchdog on cycles with no beat accepted
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || done)
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("bragg_edge_elastic_scatter_top_test NOT OK");
			$finish;
		end
	end

	initial begin
		errors = 0;
		beats_out = 0;
		queries_sent = 0;
		idle_pct = 12;
		idle_cycles = 0;
		done = 1'b0;
		count_mirror = 9'd1;
		for (int i = 0; i < DEPTH; i++) begin
			edge_mirror[i] = '0;
			strength_mirror[i] = '0;
		end
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(14, 60);
		done = 1'b1;
		drain_results();
		$display("Covered %0d results, %0d queries, edge counts 0 to 511, tables up to 256.",
			beats_out, queries_sent);
		if (errors == 0) begin
			$display("bragg_edge_elastic_scatter_top_test OK");
		end else begin
			$display("bragg_edge_elastic_scatter_top_test NOT OK");
		end
		$finish;
	end

endmodule
